@@ rtl/core/line_index_locator_unit_assert.svh @@
// assertion macros for the line index locator
`ifndef LINE_INDEX_LOCATOR_UNIT_ASSERT_SVH
`define LINE_INDEX_LOCATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LIL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LIL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LIL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LIL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/core/lil_pkg.sv @@
// shared constants and types for the line index locator
package lil_pkg;

    localparam int MAX_LINES      = 4096;
    localparam int IDX_W          = $clog2(MAX_LINES);
    localparam int CNT_W          = IDX_W + 1;
    localparam int TEXT_W         = 16;
    localparam int COL_W          = TEXT_W + 1;
    localparam int MAX_TEXT_BYTES = 65535;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_BYTE   = 2'd1,
        MODE_LOCATE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP
    } search_state_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] line;
        logic [COL_W-1:0] column;
    } search_res_t;

endpackage

@@ rtl/core/lil_line_ram.sv @@
// line start table memory, one write port and one registered read port
module lil_line_ram
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [lil_pkg::IDX_W-1:0]  wr_addr,
    input  logic [lil_pkg::TEXT_W-1:0] wr_data,
    input  lil_pkg::rd_req_t           rd_req,
    output logic [lil_pkg::TEXT_W-1:0] rd_data
);

    logic [lil_pkg::TEXT_W-1:0] mem [lil_pkg::MAX_LINES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_req.en)
        begin
            rd_data <= mem[rd_req.addr];
        end
    end

endmodule

@@ rtl/core/lil_search.sv @@
// binary search sequencer over the line start table
`include "line_index_locator_unit_assert.svh"

module lil_search
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       launch,
    input  logic [lil_pkg::TEXT_W-1:0] span_start,
    input  logic [lil_pkg::CNT_W-1:0]  line_total,
    input  logic [lil_pkg::TEXT_W-1:0] rd_data,
    output lil_pkg::rd_req_t           rd_req,
    output lil_pkg::search_res_t       res,
    output logic                       busy
);

    lil_pkg::search_state_t state_reg, state_next;
    logic [lil_pkg::IDX_W-1:0]  first_reg, first_next;
    logic [lil_pkg::CNT_W-1:0]  after_reg, after_next;
    logic [lil_pkg::IDX_W-1:0]  mid_reg, mid_next;
    logic [lil_pkg::TEXT_W-1:0] base_reg, base_next;
    logic [lil_pkg::TEXT_W-1:0] key_reg, key_next;

    logic [lil_pkg::CNT_W-1:0]  first_ext;
    logic [lil_pkg::CNT_W-1:0]  span;
    logic [lil_pkg::CNT_W-1:0]  middle;
    logic                       more;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lil_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        after_reg <= after_next;
        mid_reg   <= mid_next;
        base_reg  <= base_next;
        key_reg   <= key_next;
    end

    assign first_ext = {1'b0, first_reg};
    assign span      = after_reg - first_ext;
    assign middle    = first_ext + (span >> 1);
    assign more      = (first_ext + lil_pkg::CNT_W'(1)) < after_reg;

    always_comb
    begin
        state_next  = state_reg;
        first_next  = first_reg;
        after_next  = after_reg;
        mid_next    = mid_reg;
        base_next   = base_reg;
        key_next    = key_reg;
        rd_req.en   = 1'b0;
        rd_req.addr = middle[lil_pkg::IDX_W-1:0];
        res.done    = 1'b0;
        res.line    = first_ext + lil_pkg::CNT_W'(1);
        res.column  = {1'b0, key_reg} - {1'b0, base_reg} + lil_pkg::COL_W'(1);
        unique case (state_reg)
            lil_pkg::S_IDLE:
            begin
                if (launch)
                begin
                    first_next = '0;
                    after_next = line_total;
                    base_next  = '0;
                    key_next   = span_start;
                    state_next = lil_pkg::S_PROBE;
                end
            end
            lil_pkg::S_PROBE:
            begin
                if (more)
                begin
                    rd_req.en  = 1'b1;
                    mid_next   = middle[lil_pkg::IDX_W-1:0];
                    state_next = lil_pkg::S_CMP;
                end
                else
                begin
                    res.done   = 1'b1;
                    state_next = lil_pkg::S_IDLE;
                end
            end
            lil_pkg::S_CMP:
            begin
                if (rd_data <= key_reg)
                begin
                    first_next = mid_reg;
                    base_next  = rd_data;
                end
                else
                begin
                    after_next = {1'b0, mid_reg};
                end
                state_next = lil_pkg::S_PROBE;
            end
            default:
            begin
                state_next = lil_pkg::S_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != lil_pkg::S_IDLE);

    `LIL_ASSERT_IMP(a_probe_in_range, clk, rst_n, rd_req.en, (rd_req.addr > first_reg) && ({1'b0, rd_req.addr} < after_reg), "probe outside search window")
    `LIL_ASSERT_IMP(a_base_not_above_key, clk, rst_n, res.done, base_reg <= key_reg, "line start above span start")
    `LIL_ASSERT_NXT(a_launch_busy, clk, rst_n, launch && !busy, busy, "search did not start")

endmodule

@@ rtl/core/line_index_locator_unit.sv @@
// line index locator top level: text ingest, line table and locate results
//
// usage:
//   a request is taken when start is high and busy is low; mode selects
//   new file (0), text byte (1) or locate span (2); mode 3 is ignored
//   new file and text byte requests finish in the cycle they are taken,
//   so busy stays low; one byte can be taken every cycle while no locate runs
//   a locate request raises busy while the binary search runs; each probe
//   is one table read in the probe state followed by one compare in the
//   compare state
//   an invalid span gives its result in the cycle after the request
//   results appear on span_ok, line_number, column_number and overflowed
//   for one cycle with done high; the receiver cannot stall them
//   the search rate is set by the single read port of the table memory
//   reset leaves one line, zero text length and overflow clear; the
//   table memory needs no clearing pass since only written entries are read
module line_index_locator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  text_byte,
    input  logic [15:0] span_start,
    input  logic [15:0] span_end,
    output logic        done,
    output logic        span_ok,
    output logic [12:0] line_number,
    output logic [16:0] column_number,
    output logic        overflowed
);

    logic [lil_pkg::CNT_W-1:0]  line_total_reg, line_total_next;
    logic [lil_pkg::TEXT_W-1:0] text_length_reg, text_length_next;
    logic                       overflow_reg, overflow_next;

    logic                       done_reg;
    logic                       span_ok_reg;
    logic [lil_pkg::CNT_W-1:0]  line_reg;
    logic [lil_pkg::COL_W-1:0]  column_reg;
    logic                       overflowed_reg;

    logic                       accept;
    logic                       span_valid;
    logic                       launch;
    logic                       bad_span;
    logic                       wr_en;
    logic [lil_pkg::IDX_W-1:0]  wr_addr;
    logic [lil_pkg::TEXT_W-1:0] wr_data;
    logic [lil_pkg::TEXT_W-1:0] rd_data;
    logic                       search_busy;
    lil_pkg::rd_req_t           rd_req;
    lil_pkg::search_res_t       res;

    assign accept     = start && !busy;
    assign span_valid = (span_start <= span_end) && (span_end <= text_length_reg);
    assign launch     = accept && (mode == lil_pkg::MODE_LOCATE) && span_valid;
    assign bad_span   = accept && (mode == lil_pkg::MODE_LOCATE) && !span_valid;

    always_comb
    begin
        line_total_next  = line_total_reg;
        text_length_next = text_length_reg;
        overflow_next    = overflow_reg;
        wr_en            = 1'b0;
        wr_addr          = line_total_reg[lil_pkg::IDX_W-1:0];
        wr_data          = text_length_reg + lil_pkg::TEXT_W'(1);
        if (accept)
        begin
            case (mode)
                lil_pkg::MODE_CLEAR:
                begin
                    line_total_next  = lil_pkg::CNT_W'(1);
                    text_length_next = '0;
                    overflow_next    = 1'b0;
                end
                lil_pkg::MODE_BYTE:
                begin
                    if (text_length_reg >= lil_pkg::TEXT_W'(lil_pkg::MAX_TEXT_BYTES))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        if (text_byte == lil_pkg::NEWLINE_BYTE)
                        begin
                            if (line_total_reg < lil_pkg::CNT_W'(lil_pkg::MAX_LINES))
                            begin
                                wr_en           = 1'b1;
                                line_total_next = line_total_reg + lil_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        text_length_next = text_length_reg + lil_pkg::TEXT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_total_reg  <= lil_pkg::CNT_W'(1);
            text_length_reg <= '0;
            overflow_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            line_total_reg  <= line_total_next;
            text_length_reg <= text_length_next;
            overflow_reg    <= overflow_next;
            done_reg        <= bad_span || res.done;
        end
    end

    always_ff @(posedge clk)
    begin
        span_ok_reg    <= res.done;
        line_reg       <= res.done ? res.line : '0;
        column_reg     <= res.done ? res.column : '0;
        overflowed_reg <= overflow_reg;
    end

    lil_line_ram u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    lil_search u_search
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .launch     (launch),
        .span_start (span_start),
        .line_total (line_total_reg),
        .rd_data    (rd_data),
        .rd_req     (rd_req),
        .res        (res),
        .busy       (search_busy)
    );

    assign busy          = search_busy;
    assign done          = done_reg;
    assign span_ok       = span_ok_reg;
    assign line_number   = line_reg;
    assign column_number = column_reg;
    assign overflowed    = overflowed_reg;

    `LIL_ASSERT_IMP(a_line_total_range, clk, rst_n, 1'b1, (line_total_reg != '0) && (line_total_reg <= lil_pkg::CNT_W'(lil_pkg::MAX_LINES)), "line count out of range")
    `LIL_ASSERT_NXT(a_search_result, clk, rst_n, res.done, done_reg && span_ok_reg, "search result lost")
    `LIL_ASSERT_NXT(a_clear_file, clk, rst_n, accept && (mode == lil_pkg::MODE_CLEAR), (line_total_reg == lil_pkg::CNT_W'(1)) && (text_length_reg == '0) && !overflow_reg, "new file did not clear state")

endmodule

@@ bench/tb_top.sv @@
// self-checking testbench for line_index_locator_unit: text ingest and span locate requests
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         CYCLE_LIMIT     = 600000;
    localparam int         DRAIN_CYCLES    = 40;
    localparam int         RANDOM_REQUESTS = 800;
    localparam int         REPORT_LIMIT    = 10;

    typedef struct {
        logic        ok;
        logic [12:0] line;
        logic [16:0] column;
        logic        ovf;
    } span_location_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  mode        = lil_pkg::MODE_CLEAR;
    logic [7:0]  text_byte   = 8'd0;
    logic [15:0] span_start  = 16'd0;
    logic [15:0] span_end    = 16'd0;
    logic        busy;
    logic        done;
    logic        span_ok;
    logic [12:0] line_number;
    logic [16:0] column_number;
    logic        overflowed;

    // predicted copy of the line table and file state
    logic [15:0] exp_line_table [lil_pkg::MAX_LINES];
    int          line_cnt;
    int          text_len;
    logic        ovf_flag;

    span_location_t pending_locations [$];

    int  error_count    = 0;
    int  request_count  = 0;
    int  locate_checked = 0;
    int  in_range_seen  = 0;
    int  overflow_seen  = 0;
    int  cycle_count    = 0;
    bit  idle_on        = 1'b1;

    line_index_locator_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .text_byte     (text_byte),
        .span_start    (span_start),
        .span_end      (span_end),
        .done          (done),
        .span_ok       (span_ok),
        .line_number   (line_number),
        .column_number (column_number),
        .overflowed    (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_locations.size());
            $display("line_index_locator_unit test failed");
            $finish;
        end
    end

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic void file_clear();
        exp_line_table[0] = 16'd0;
        line_cnt          = 1;
        text_len          = 0;
        ovf_flag          = 1'b0;
    endfunction

    function automatic void file_take_byte(logic [7:0] b);
        if (text_len >= lil_pkg::MAX_TEXT_BYTES)
        begin
            ovf_flag = 1'b1;
        end
        else
        begin
            if (b == lil_pkg::NEWLINE_BYTE)
            begin
                if (line_cnt < lil_pkg::MAX_LINES)
                begin
                    exp_line_table[line_cnt] = 16'(text_len + 1);
                    line_cnt++;
                end
                else
                begin
                    ovf_flag = 1'b1;
                end
            end
            text_len++;
        end
    endfunction

    function automatic span_location_t locate_span(logic [15:0] s, logic [15:0] e);
        span_location_t r;
        int lo;
        int hi;
        int mid;
        r.ok     = (s <= e) && (int'(e) <= text_len);
        r.line   = 13'd0;
        r.column = 17'd0;
        r.ovf    = ovf_flag;
        if (r.ok)
        begin
            lo = 0;
            hi = line_cnt;
            while (lo + 1 < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (exp_line_table[mid] <= s)
                    lo = mid;
                else
                    hi = mid;
            end
            r.line   = 13'(lo + 1);
            r.column = 17'(s) - 17'(exp_line_table[lo]) + 17'd1;
        end
        return r;
    endfunction

    // result check and request tracking, both on pre-edge values
    always @(posedge clk)
    begin
        span_location_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (pending_locations.size() == 0)
                begin
                    report_error("result strobe with no locate request pending");
                end
                else
                begin
                    want = pending_locations.pop_front();
                    locate_checked++;
                    if (span_ok === 1'b1)
                        in_range_seen++;
                    if (overflowed === 1'b1)
                        overflow_seen++;
                    if (span_ok !== want.ok || line_number !== want.line ||
                        column_number !== want.column || overflowed !== want.ovf)
                        report_error($sformatf(
                            "locate mismatch: exp ok=%0b line=%0d col=%0d ovf=%0b, got ok=%0b line=%0d col=%0d ovf=%0b",
                            want.ok, want.line, want.column, want.ovf,
                            span_ok, line_number, column_number, overflowed));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                case (mode)
                    lil_pkg::MODE_CLEAR:  file_clear();
                    lil_pkg::MODE_BYTE:   file_take_byte(text_byte);
                    lil_pkg::MODE_LOCATE:
                        pending_locations.push_back(locate_span(span_start, span_end));
                    default:     ;
                endcase
            end
        end
    end

    // call right after a rising edge; returns after the request is taken and any idle gap
    task automatic send_req(logic [1:0] m, logic [7:0] b, logic [15:0] s, logic [15:0] e);
        int gap;
        int pick;
        start      <= 1'b1;
        mode       <= m;
        text_byte  <= b;
        span_start <= s;
        span_end   <= e;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (m != MODE_UNUSED)
            request_count++;
        gap = 0;
        if (idle_on)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                gap = 0;
            else if (pick < 85)
                gap = $urandom_range(1, 3);
            else if (pick < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic new_file();
        send_req(lil_pkg::MODE_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic put_byte(logic [7:0] b);
        send_req(lil_pkg::MODE_BYTE, b, 16'($urandom), 16'($urandom));
    endtask

    task automatic locate(logic [15:0] s, logic [15:0] e);
        send_req(lil_pkg::MODE_LOCATE, 8'($urandom), s, e);
    endtask

    task automatic test_after_reset();
        locate(16'd0, 16'd0);
        locate(16'd0, 16'd1);
        send_req(MODE_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
        locate(16'hFFFF, 16'hFFFF);
        locate(16'hFFFF, 16'd0);
    endtask

    task automatic test_short_text();
        new_file();
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(lil_pkg::NEWLINE_BYTE);
        put_byte(lil_pkg::NEWLINE_BYTE);
        put_byte(8'h41);
        put_byte(lil_pkg::NEWLINE_BYTE);
        locate(16'd0, 16'd6);
        locate(16'd2, 16'd3);
        locate(16'd3, 16'd3);
        locate(16'd4, 16'd5);
        locate(16'd5, 16'd6);
        locate(16'd6, 16'd6);
        locate(16'd6, 16'd7);
        locate(16'd3, 16'd2);
    endtask

    task automatic test_line_table_full();
        new_file();
        idle_on = 1'b0;
        repeat (lil_pkg::MAX_LINES - 1) put_byte(lil_pkg::NEWLINE_BYTE);
        idle_on = 1'b1;
        locate(16'(lil_pkg::MAX_LINES - 1), 16'(lil_pkg::MAX_LINES - 1));
        put_byte(lil_pkg::NEWLINE_BYTE);
        put_byte(8'h7A);
        locate(16'(lil_pkg::MAX_LINES), 16'(lil_pkg::MAX_LINES + 1));
        locate(16'(lil_pkg::MAX_LINES + 1), 16'(lil_pkg::MAX_LINES + 1));
        locate(16'd0, 16'(lil_pkg::MAX_LINES + 1));
        locate(16'(lil_pkg::MAX_LINES / 2), 16'(lil_pkg::MAX_LINES / 2));
        locate(16'(lil_pkg::MAX_LINES + 1), 16'(lil_pkg::MAX_LINES + 2));
        new_file();
        locate(16'd0, 16'd0);
    endtask

    task automatic test_text_limit();
        logic [15:0] s;
        logic [15:0] e;
        new_file();
        idle_on = 1'b0;
        repeat (lil_pkg::MAX_TEXT_BYTES)
            put_byte(($urandom_range(0, 63) == 0) ? lil_pkg::NEWLINE_BYTE : 8'($urandom));
        idle_on = 1'b1;
        locate(16'hFFFF, 16'hFFFF);
        locate(16'd0, 16'hFFFF);
        put_byte(lil_pkg::NEWLINE_BYTE);
        put_byte(8'($urandom));
        locate(16'hFFFE, 16'hFFFF);
        locate(16'hFFFF, 16'hFFFF);
        repeat (24)
        begin
            e = 16'($urandom_range(0, 65535));
            s = 16'($urandom_range(0, e));
            locate(s, e);
        end
        new_file();
    endtask

    task automatic test_random();
        int          pick;
        int          sel;
        int          idx;
        logic [15:0] s;
        logic [15:0] e;
        int          sent;
        sent = 0;
        idle_on = 1'b1;
        while (sent < RANDOM_REQUESTS)
        begin
            // bursts with and without idle gaps
            if ($urandom_range(0, 99) == 0)
                idle_on = !idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                new_file();
                sent++;
            end
            else if (pick < 6)
            begin
                send_req(MODE_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
            end
            else if (pick < 70)
            begin
                if ($urandom_range(0, 99) < 30)
                    put_byte(lil_pkg::NEWLINE_BYTE);
                else
                    put_byte(8'($urandom));
                sent++;
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                begin
                    e = 16'($urandom_range(0, text_len));
                    s = 16'($urandom_range(0, e));
                end
                else if (sel < 75)
                begin
                    // near a line start
                    idx = $urandom_range(0, line_cnt - 1);
                    s = exp_line_table[idx];
                    if (s > 0 && $urandom_range(0, 1) == 1)
                        s = s - 16'd1;
                    e = 16'(text_len);
                end
                else if (sel < 88)
                begin
                    s = 16'($urandom);
                    e = 16'($urandom);
                end
                else if (text_len > 0)
                begin
                    s = 16'($urandom_range(1, text_len));
                    e = 16'($urandom_range(0, s - 1));
                end
                else
                begin
                    s = 16'd0;
                    e = 16'(text_len + $urandom_range(1, 5));
                end
                locate(s, e);
                sent++;
            end
        end
    endtask

    initial
    begin
        file_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_short_text();
        test_line_table_full();
        test_text_limit();
        test_random();

        start <= 1'b0;
        while (pending_locations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests, %0d locate results checked (%0d in range, %0d with overflow set)",
                 request_count, locate_checked, in_range_seen, overflow_seen);
        $display("covered reset state, short text, full line table, text limit and random traffic; %0d errors",
                 error_count);
        if (error_count == 0)
            $display("line_index_locator_unit test passed");
        else
            $display("line_index_locator_unit test failed");
        $finish;
    end

endmodule
